@@ design/rbd_pkg.sv @@
// Shared types and constants for the ring buffer deque unit.
// No dependencies; compiled first.
package rbd_pkg;

    localparam int CAP_W      = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int PDATA_W    = 32;
    localparam int FIELD_W    = 32;

    localparam logic [CAP_W-1:0] CAP_RESET    = 4'd15;
    localparam logic             REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic take;
        logic exec;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic pop_ok;
    } t_dp_sts;

endpackage

@@ design/rbd_if.sv @@
// Valid/ready channel interfaces for request and result items.
// Depends on rbd_pkg.
interface rbd_req_if import rbd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    t_op                       op;
    logic signed [FIELD_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface rbd_rsp_if import rbd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] data_out;
    t_status                   status;
    logic                      is_empty;
    logic                      is_full;

    modport source (output valid, output data_out, output status, output is_empty,
                    output is_full, input ready);
    modport sink   (input valid, input data_out, input status, input is_empty,
                    input is_full, output ready);
endinterface

@@ design/rbd_datapath.sv @@
// Datapath: capacity register, ring pointers, slot memory and result register.
// Depends on rbd_pkg; driven by rbd_controller commands.
module rbd_datapath import rbd_pkg::*; #(
    parameter int SLOTS      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic                      i_cfg_we,
    input  logic [CAP_W-1:0]          i_cfg_data,
    output logic [CAP_W-1:0]          o_cap,
    input  t_op                       i_op,
    input  logic [FIELD_W-1:0]        i_value,
    output logic [FIELD_W-1:0]        o_data_out,
    output t_status                   o_status,
    output logic                      o_is_empty,
    output logic                      o_is_full
);

    localparam int IW  = $clog2(SLOTS);
    localparam int LIM = SLOTS - 1;

    logic [CAP_W-1:0]      r_cap;
    logic [IW-1:0]         r_front, n_front;
    logic [IW-1:0]         r_rear, n_rear;
    t_op                   r_op;
    logic [FIELD_W-1:0]    r_value;
    logic [DATA_WIDTH-1:0] r_mem [SLOTS];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [FIELD_W-1:0]    r_data_out;
    t_status               r_status, n_status;
    logic                  r_empty;
    logic                  r_full;

    logic [IW-1:0]         w_last;
    logic                  w_empty;
    logic                  w_full;
    logic [IW-1:0]         w_front_next;
    logic [IW-1:0]         w_front_prev;
    logic [IW-1:0]         w_rear_next;
    logic [IW-1:0]         w_rear_prev;
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic                  w_re;
    logic [IW-1:0]         w_raddr;
    logic [63:0]           w_val64;
    logic [63:0]           w_rd64;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] idx,
                                             input logic [IW-1:0] last);
        return (idx == last) ? '0 : idx + IW'(1);
    endfunction

    function automatic logic [IW-1:0] f_prev(input logic [IW-1:0] idx,
                                             input logic [IW-1:0] last);
        return (idx == '0) ? last : idx - IW'(1);
    endfunction

    always_comb begin
        if (r_cap == '0) begin
            w_last = IW'(1);
        end else if (int'(r_cap) > LIM) begin
            w_last = IW'(LIM);
        end else begin
            w_last = IW'(r_cap);
        end
    end

    assign w_empty      = (r_front == r_rear);
    assign w_rear_next  = f_next(r_rear, w_last);
    assign w_rear_prev  = f_prev(r_rear, w_last);
    assign w_front_next = f_next(r_front, w_last);
    assign w_front_prev = f_prev(r_front, w_last);
    assign w_full       = (w_rear_next == r_front);
    assign w_val64      = 64'(r_value);
    assign w_rd64       = 64'(r_rd_data);

    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_status = ST_DONE;
        w_we     = 1'b0;
        w_waddr  = r_front;
        w_re     = 1'b0;
        w_raddr  = r_rear;
        o_sts.pop_ok = 1'b0;
        unique case (r_op)
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_front;
                    n_front = w_front_prev;
                end
            end
            OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_rear_next;
                    n_rear  = w_rear_next;
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_re         = 1'b1;
                    w_raddr      = w_front_next;
                    n_front      = w_front_next;
                    o_sts.pop_ok = 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_re         = 1'b1;
                    w_raddr      = r_rear;
                    n_rear       = w_rear_prev;
                    o_sts.pop_ok = 1'b1;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_front <= '0;
            r_rear  <= '0;
        end else if (i_cfg_we) begin
            r_cap   <= i_cfg_data;
            r_front <= '0;
            r_rear  <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_rear  <= n_rear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_data_out <= '0;
            r_status   <= n_status;
            r_empty    <= (n_front == n_rear);
            r_full     <= (f_next(n_rear, w_last) == n_front);
        end else if (i_cmd.load) begin
            r_data_out <= w_rd64[FIELD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[w_waddr] <= w_val64[DATA_WIDTH-1:0];
        end
        if (i_cmd.exec && w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    assign o_cap      = r_cap;
    assign o_data_out = r_data_out;
    assign o_status   = r_status;
    assign o_is_empty = r_empty;
    assign o_is_full  = r_full;

    a_ptr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_front <= w_last) && (r_rear <= w_last))
        else $error("ring pointer beyond active slot count");

endmodule

@@ design/rbd_controller.sv @@
// Controller state machine: input handshake, execute and load sequencing,
// result valid flag. Depends on rbd_pkg.
module rbd_controller import rbd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_room;
    logic   w_set;

    assign w_room = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        w_set      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_room) begin
                    o_cmd.exec = 1'b1;
                    if (i_sts.pop_ok) begin
                        n_state = S_LOAD;
                    end else begin
                        w_set   = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                w_set      = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || w_set;
    end

    assign o_out_valid = r_out_valid;

    a_load_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> $past(r_state == S_EXEC && i_sts.pop_ok))
        else $error("load step without a successful pop");

    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !r_out_valid)
        else $error("result register occupied during load");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC || r_state == S_LOAD))
        else $error("result valid raised outside execute or load");

endmodule

@@ design/ring_buffer_deque_unit.sv @@
// Top level of the ring buffer deque unit: APB register decode and wiring of
// controller and datapath. Depends on rbd_pkg, rbd_if, rbd_controller, rbd_datapath.
//
// A push, or any rejected operation, passes through the accept and execute
// states; a successful pop adds a load state, needed because the slot memory
// has a registered read port. A new item is taken once the unit is back in
// its idle state, while an earlier result may still wait in the output
// register. Writing the capacity register empties the deque.
module ring_buffer_deque_unit import rbd_pkg::*; #(
    parameter int SLOTS      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rbd_req_if.sink               i_req,
    rbd_rsp_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic             w_cfg_we;
    logic [CAP_W-1:0] w_cap;
    logic [FIELD_W-1:0] w_data_out;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata   = (paddr[2] == REG_CAPACITY) ? PDATA_W'(w_cap) : '0;

    rbd_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    rbd_datapath #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (w_cfg_we),
        .i_cfg_data (pwdata[CAP_W-1:0]),
        .o_cap      (w_cap),
        .i_op       (i_req.op),
        .i_value    (i_req.value),
        .o_data_out (w_data_out),
        .o_status   (o_rsp.status),
        .o_is_empty (o_rsp.is_empty),
        .o_is_full  (o_rsp.is_full)
    );

    assign o_rsp.data_out = w_data_out;

endmodule
